// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define P2A_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("p2a assertion failed");

// next-cycle implication, held off during reset
`define P2A_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("p2a assertion failed");

`endif

// ===== src/p2a_enc_pkg.sv =====
// shared types, character codes, microcode table and digit split for the encoder
`default_nettype none

package p2a_enc_pkg;

    localparam int UCODE_LEN = 25;
    localparam int STEP_W    = $clog2(UCODE_LEN);

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // entry points of the program
    localparam logic [STEP_W-1:0] STEP_ESC   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_SPACE = STEP_W'(19);

    typedef enum logic {
        OP_CONST,
        OP_DIGIT
    } uop_t;

    typedef enum logic [1:0] {
        COMP_R,
        COMP_G,
        COMP_B
    } comp_t;

    typedef enum logic [1:0] {
        PL_HUND,
        PL_TENS,
        PL_UNIT
    } place_t;

    // condition under which a step puts out its byte
    typedef enum logic [1:0] {
        C_ALWAYS,
        C_GE100,
        C_GE10
    } ucond_t;

    // condition under which a step ends the pixel
    typedef enum logic [1:0] {
        F_NEVER,
        F_NOROW,
        F_NOFRAME,
        F_ALWAYS
    } ufin_t;

    typedef struct packed {
        uop_t       op;
        logic [7:0] chr;
        comp_t      comp;
        place_t     place;
        ucond_t     cond;
        ufin_t      fin;
    } uword_t;

    function automatic uword_t p2a_const(input logic [7:0] chr, input ufin_t fin);
        uword_t w;
        w.op    = OP_CONST;
        w.chr   = chr;
        w.comp  = COMP_R;
        w.place = PL_UNIT;
        w.cond  = C_ALWAYS;
        w.fin   = fin;
        return w;
    endfunction

    function automatic uword_t p2a_digit(input comp_t comp, input place_t place,
                                         input ucond_t cond);
        uword_t w;
        w.op    = OP_DIGIT;
        w.chr   = CH_ZERO;
        w.comp  = comp;
        w.place = place;
        w.cond  = cond;
        w.fin   = F_NEVER;
        return w;
    endfunction

    // control store: one word per step
    function automatic uword_t p2a_ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            5'd0:    w = p2a_const(CH_ESC, F_NEVER);
            5'd1:    w = p2a_const(CH_LBRK, F_NEVER);
            5'd2:    w = p2a_const(CH_FOUR, F_NEVER);
            5'd3:    w = p2a_const(CH_EIGHT, F_NEVER);
            5'd4:    w = p2a_const(CH_SEMI, F_NEVER);
            5'd5:    w = p2a_const(CH_TWO, F_NEVER);
            5'd6:    w = p2a_const(CH_SEMI, F_NEVER);
            5'd7:    w = p2a_digit(COMP_R, PL_HUND, C_GE100);
            5'd8:    w = p2a_digit(COMP_R, PL_TENS, C_GE10);
            5'd9:    w = p2a_digit(COMP_R, PL_UNIT, C_ALWAYS);
            5'd10:   w = p2a_const(CH_SEMI, F_NEVER);
            5'd11:   w = p2a_digit(COMP_G, PL_HUND, C_GE100);
            5'd12:   w = p2a_digit(COMP_G, PL_TENS, C_GE10);
            5'd13:   w = p2a_digit(COMP_G, PL_UNIT, C_ALWAYS);
            5'd14:   w = p2a_const(CH_SEMI, F_NEVER);
            5'd15:   w = p2a_digit(COMP_B, PL_HUND, C_GE100);
            5'd16:   w = p2a_digit(COMP_B, PL_TENS, C_GE10);
            5'd17:   w = p2a_digit(COMP_B, PL_UNIT, C_ALWAYS);
            5'd18:   w = p2a_const(CH_M, F_NEVER);
            5'd19:   w = p2a_const(CH_SPACE, F_NOROW);
            5'd20:   w = p2a_const(CH_NL, F_NOFRAME);
            5'd21:   w = p2a_const(CH_ESC, F_NEVER);
            5'd22:   w = p2a_const(CH_LBRK, F_NEVER);
            5'd23:   w = p2a_const(CH_ZERO, F_NEVER);
            5'd24:   w = p2a_const(CH_M, F_ALWAYS);
            default: w = p2a_const(CH_M, F_ALWAYS);
        endcase
        return w;
    endfunction

    // splits 0..255 into {hundreds[1:0], tens[3:0], units[3:0]}
    function automatic logic [9:0] p2a_to_bcd(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [6:0]  tx10;
        logic [3:0]  u;
        if (v >= 8'd200)
        begin
            h = 2'd2;
            r = 7'(v - 8'd200);
        end
        else if (v >= 8'd100)
        begin
            h = 2'd1;
            r = 7'(v - 8'd100);
        end
        else
        begin
            h = 2'd0;
            r = v[6:0];
        end
        // r < 100, so r * 205 >> 11 is r / 10
        prod = 15'(r) * 15'd205;
        t    = prod[14:11];
        tx10 = 7'(t) * 7'd10;
        u    = 4'(r - tx10);
        return {h, t, u};
    endfunction

endpackage

`default_nettype wire

// ===== src/p2a_enc_if.sv =====
// valid/ready channels for pixels in and terminal bytes out
`default_nettype none

interface p2a_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output red, output green, output blue,
                    output row_end, output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input row_end, input frame_end, output ready);
endinterface

interface p2a_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

// ===== src/pixel_to_ansi_truecolor_encoder_unit.sv =====
// pixel to ansi 24-bit background color byte stream encoder, microcoded
//
//  channel | dir | request contents
//  --------+-----+-------------------------------------------
//  pixel   | in  | red, green, blue, row_end, frame_end
//  text    | out | out_byte, run_last (final byte of a pixel)
//
// a pixel is taken while the sequencer is idle, then the sequencer walks one control
// word per cycle while text is not stalled: 1 to 25 steps per pixel.
// leading-zero digit steps are skipped without putting out a byte.
// a text stall holds the sequencer; a new pixel is taken once its final byte
// sits in the output register. reset clears the sequencer and the color memory.
`default_nettype none

module pixel_to_ansi_truecolor_encoder_unit
    import p2a_enc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    p2a_pix_if.sink     pixel,
    p2a_byte_if.source  text
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] pc_reg, pc_next;
    logic              known_reg, known_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        sent_red_reg, sent_green_reg, sent_blue_reg;
    logic              rend_reg, fend_reg;
    logic [9:0]        bcd_r_reg, bcd_g_reg, bcd_b_reg;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg;

    uword_t     uw;
    logic [9:0] bcd_sel;
    logic [3:0] digit;
    logic       emit;
    logic       fin_hit;
    logic       done;
    logic       fire;
    logic       accept;
    logic       change;
    logic       rend_in;
    logic [7:0] byte_val;

    assign pixel.ready    = !busy_reg;
    assign accept         = pixel.valid && !busy_reg;
    assign rend_in        = pixel.row_end || pixel.frame_end;
    assign change         = !known_reg || (pixel.red != sent_red_reg)
                            || (pixel.green != sent_green_reg)
                            || (pixel.blue != sent_blue_reg);

    assign text.valid     = out_valid_reg;
    assign text.out_byte  = out_byte_reg;
    assign text.run_last  = run_last_reg;

    always_comb
    begin
        uw = p2a_ucode(pc_reg);

        case (uw.comp)
            COMP_R:  bcd_sel = bcd_r_reg;
            COMP_G:  bcd_sel = bcd_g_reg;
            COMP_B:  bcd_sel = bcd_b_reg;
            default: bcd_sel = bcd_b_reg;
        endcase

        case (uw.place)
            PL_HUND: digit = {2'b00, bcd_sel[9:8]};
            PL_TENS: digit = bcd_sel[7:4];
            PL_UNIT: digit = bcd_sel[3:0];
            default: digit = bcd_sel[3:0];
        endcase

        case (uw.cond)
            C_ALWAYS: emit = 1'b1;
            C_GE100:  emit = (bcd_sel[9:8] != 2'd0);
            C_GE10:   emit = (bcd_sel[9:8] != 2'd0) || (bcd_sel[7:4] != 4'd0);
            default:  emit = 1'b1;
        endcase

        case (uw.fin)
            F_NEVER:   fin_hit = 1'b0;
            F_NOROW:   fin_hit = !rend_reg;
            F_NOFRAME: fin_hit = !fend_reg;
            F_ALWAYS:  fin_hit = 1'b1;
            default:   fin_hit = 1'b1;
        endcase

        case (uw.op)
            OP_CONST: byte_val = uw.chr;
            OP_DIGIT: byte_val = CH_ZERO + {4'b0000, digit};
            default:  byte_val = uw.chr;
        endcase

        done = emit && fin_hit;
        // a skipped step never waits on the output register
        fire = busy_reg && (!emit || !out_valid_reg || text.ready);

        busy_next      = busy_reg;
        pc_next        = pc_reg;
        known_next     = known_reg;
        out_valid_next = out_valid_reg && !text.ready;

        if (accept)
        begin
            busy_next  = 1'b1;
            pc_next    = change ? STEP_ESC : STEP_SPACE;
            // a row or frame end forgets the color; otherwise the color is now sent
            known_next = !rend_in;
        end
        else if (fire)
        begin
            if (emit)
            begin
                out_valid_next = 1'b1;
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = STEP_W'(pc_reg + STEP_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= STEP_ESC;
            known_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            sent_red_reg   <= 8'd0;
            sent_green_reg <= 8'd0;
            sent_blue_reg  <= 8'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            known_reg     <= known_next;
            out_valid_reg <= out_valid_next;
            if (accept && change)
            begin
                sent_red_reg   <= pixel.red;
                sent_green_reg <= pixel.green;
                sent_blue_reg  <= pixel.blue;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rend_reg  <= rend_in;
            fend_reg  <= pixel.frame_end;
            bcd_r_reg <= p2a_to_bcd(pixel.red);
            bcd_g_reg <= p2a_to_bcd(pixel.green);
            bcd_b_reg <= p2a_to_bcd(pixel.blue);
        end
        if (fire && emit)
        begin
            out_byte_reg <= byte_val;
            run_last_reg <= done;
        end
    end

endmodule

`default_nettype wire

// ===== src/p2a_enc_checker.sv =====
// port-level checks for the encoder, bound into the encoder module
`default_nettype none
`include "assert_macros.svh"

module p2a_enc_checker
    import p2a_enc_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       run_last
);

    logic       in_acc;
    logic       out_stall;
    logic [8:0] out_word;
    logic       text_char;

    assign in_acc    = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign out_word  = {out_byte, run_last};
    assign text_char = out_byte inside {CH_ESC, CH_LBRK, CH_SEMI, CH_M, CH_SPACE, CH_NL,
                                        [CH_ZERO:CH_NINE]};

    // a stalled byte holds
    `P2A_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))

    // a taken pixel closes the input
    `P2A_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_acc, !in_ready)

    // when open for a new pixel, any waiting byte is the last of the previous one
    `P2A_ASSERT_NOW(a_idle_last, clk, rst_n, in_ready && out_valid, run_last)

    // only the characters of the escape, digit and spacing alphabet appear
    `P2A_ASSERT_NOW(a_alphabet, clk, rst_n, out_valid, text_char)

endmodule

bind pixel_to_ansi_truecolor_encoder_unit p2a_enc_checker u_p2a_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_byte  (text.out_byte),
    .run_last  (text.run_last)
);

`default_nettype wire

// ===== test/pixel_to_ansi_truecolor_encoder_unit_test.sv =====
// testbench for the pixel to ansi truecolor encoder: predicted byte stream checked under stalls
`default_nettype none

module pixel_to_ansi_truecolor_encoder_unit_test;
    import p2a_enc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 400;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    p2a_pix_if  pix_ch ();
    p2a_byte_if text_ch ();

    pixel_to_ansi_truecolor_encoder_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pix_ch),
        .text  (text_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // bytes still owed by the block, oldest first
    text_byte_t text_expect[$];

    // color memory of the predicted encoder
    logic [7:0] row_red;
    logic [7:0] row_green;
    logic [7:0] row_blue;
    logic       row_color_sent;

    int err_count    = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    function automatic void push_char(input logic [7:0] ch);
        text_byte_t t;
        t.ch   = ch;
        t.last = 1'b0;
        text_expect.push_back(t);
    endfunction

    function automatic void push_decimal(input logic [7:0] v);
        int n;
        n = v;
        if (n >= 100)
            push_char(CH_ZERO + 8'(n / 100));
        if (n >= 10)
            push_char(CH_ZERO + 8'((n / 10) % 10));
        push_char(CH_ZERO + 8'(n % 10));
    endfunction

    function automatic void encode_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic re,
                                         input logic fe);
        logic row_done;
        row_done = re | fe;
        if (!row_color_sent || r != row_red || g != row_green || b != row_blue)
        begin
            push_char(CH_ESC);
            push_char(CH_LBRK);
            push_char(CH_FOUR);
            push_char(CH_EIGHT);
            push_char(CH_SEMI);
            push_char(CH_TWO);
            push_char(CH_SEMI);
            push_decimal(r);
            push_char(CH_SEMI);
            push_decimal(g);
            push_char(CH_SEMI);
            push_decimal(b);
            push_char(CH_M);
            row_red        = r;
            row_green      = g;
            row_blue       = b;
            row_color_sent = 1'b1;
        end
        push_char(CH_SPACE);
        if (row_done)
        begin
            push_char(CH_NL);
            row_color_sent = 1'b0;
        end
        if (fe)
        begin
            push_char(CH_ESC);
            push_char(CH_LBRK);
            push_char(CH_ZERO);
            push_char(CH_M);
        end
        text_expect[text_expect.size() - 1].last = 1'b1;
    endfunction

    // text side: ready with random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            text_ch.ready <= 1'b0;
        end
        else
            text_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // values are stable from the falling edge until the rising edge that takes them
    always @(negedge clk)
    begin
        text_byte_t want;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            if (text_expect.size() == 0)
            begin
                $display("%0t: unexpected byte %h run_last %b", $time,
                         text_ch.out_byte, text_ch.run_last);
                err_count++;
            end
            else
            begin
                want = text_expect.pop_front();
                if (text_ch.out_byte !== want.ch)
                begin
                    $display("%0t: out_byte expected %h actual %h", $time,
                             want.ch, text_ch.out_byte);
                    err_count++;
                end
                if (text_ch.run_last !== want.last)
                begin
                    $display("%0t: run_last expected %b actual %b", $time,
                             want.last, text_ch.run_last);
                    err_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (text_ch.valid && text_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pixel_to_ansi_truecolor_encoder_unit_test: errors");
            $finish;
        end
    end

    // entered just after a rising edge, returns just after the edge that takes the request
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic re, input logic fe);
        while ($urandom_range(99) < idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.red       <= r;
        pix_ch.green     <= g;
        pix_ch.blue      <= b;
        pix_ch.row_end   <= re;
        pix_ch.frame_end <= fe;
        @(negedge clk);
        while (!pix_ch.ready)
            @(negedge clk);
        encode_pixel(r, g, b, re, fe);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        while (text_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        // first pixel after reset escapes even for black
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        // digit count boundaries
        send_pixel(8'd9, 8'd10, 8'd99, 1'b0, 1'b0);
        send_pixel(8'd100, 8'd199, 8'd200, 1'b0, 1'b0);
        send_pixel(8'd1, 8'd90, 8'd109, 1'b0, 1'b0);
        // one component changes at a time
        send_pixel(8'd2, 8'd90, 8'd109, 1'b0, 1'b0);
        send_pixel(8'd2, 8'd91, 8'd109, 1'b0, 1'b0);
        send_pixel(8'd2, 8'd91, 8'd110, 1'b1, 1'b0);
        // same color right after a row end still escapes
        send_pixel(8'd2, 8'd91, 8'd110, 1'b0, 1'b0);
        send_pixel(8'd2, 8'd91, 8'd110, 1'b1, 1'b0);
        // single pixel rows
        send_pixel(8'd170, 8'd85, 8'd170, 1'b1, 1'b0);
        send_pixel(8'd170, 8'd85, 8'd170, 1'b1, 1'b0);
        // frame end alone acts as a row end too
        send_pixel(8'd85, 8'd170, 8'd85, 1'b0, 1'b0);
        send_pixel(8'd85, 8'd170, 8'd85, 1'b0, 1'b1);
        // color repeated across a frame end
        send_pixel(8'd85, 8'd170, 8'd85, 1'b0, 1'b0);
        send_pixel(8'd85, 8'd170, 8'd85, 1'b1, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd128, 8'd64, 8'd32, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b1, 1'b1);
        wait_drained();
    endtask

    // mostly whole frames with repeating colors, some stray row and frame marks
    task automatic test_random_frames(input int pixel_count, input int idle, input int stall);
        logic [7:0] pal_r[4];
        logic [7:0] pal_g[4];
        logic [7:0] pal_b[4];
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       re;
        logic       fe;
        int         sent;
        int         rows;
        int         cols;
        int         k;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < pixel_count)
        begin
            for (k = 0; k < 4; k++)
            begin
                pal_r[k] = 8'($urandom_range(255));
                pal_g[k] = 8'($urandom_range(255));
                pal_b[k] = 8'($urandom_range(255));
            end
            rows = $urandom_range(1, 3);
            for (int y = 0; y < rows && sent < pixel_count; y++)
            begin
                cols = $urandom_range(1, 7);
                for (int x = 0; x < cols && sent < pixel_count; x++)
                begin
                    if ($urandom_range(99) < 60)
                    begin
                        k = $urandom_range(3);
                        r = pal_r[k];
                        g = pal_g[k];
                        b = pal_b[k];
                    end
                    else
                    begin
                        r = 8'($urandom_range(255));
                        g = 8'($urandom_range(255));
                        b = 8'($urandom_range(255));
                    end
                    re = (x == cols - 1);
                    fe = (x == cols - 1) && (y == rows - 1);
                    if ($urandom_range(99) < 10)
                    begin
                        re = 1'($urandom_range(1));
                        fe = 1'($urandom_range(1));
                    end
                    send_pixel(r, g, b, re, fe);
                    sent++;
                end
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = LONG_HOLD;
        // the block fills and holds its pixel side while text is held off
        for (int i = 0; i < 12; i++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
        // sender pauses until every byte is out
        wait_drained();
        for (int i = 0; i < 12; i++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        wait_drained();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        pix_ch.valid     = 1'b0;
        pix_ch.red       = 8'd0;
        pix_ch.green     = 8'd0;
        pix_ch.blue      = 8'd0;
        pix_ch.row_end   = 1'b0;
        pix_ch.frame_end = 1'b0;
        text_ch.ready    = 1'b0;
        row_red          = 8'd0;
        row_green        = 8'd0;
        row_blue         = 8'd0;
        row_color_sent   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_frames(40, 0, 0);
        test_random_frames(40, 76, 0);
        test_random_frames(40, 0, 76);
        test_random_frames(40, 22, 22);
        test_backpressure();

        if (err_count == 0 && text_expect.size() == 0)
            $display("pixel_to_ansi_truecolor_encoder_unit_test: clean");
        else
            $display("pixel_to_ansi_truecolor_encoder_unit_test: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== pixel_to_ansi_truecolor_encoder_unit.f =====
+incdir+src
src/p2a_enc_pkg.sv
src/p2a_enc_if.sv
src/pixel_to_ansi_truecolor_encoder_unit.sv
src/p2a_enc_checker.sv
test/pixel_to_ansi_truecolor_encoder_unit_test.sv
